// ===== rtl/ats_pkg.sv =====
// ----------------------------------------------------------------------------
// ats_pkg: shared types and constants for the sorted-insert table
// Command codes, per-cell operation codes and the control bundle that is
// broadcast along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

  localparam int unsigned ATS_CAPACITY = 32;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned VAL_W        = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_GET    = 3'd3,
    CMD_SET    = 3'd4,
    CMD_SORTED = 3'd5,
    CMD_CHECK  = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_SET,
    OP_SORTED
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic [CNT_W-1:0]        pos;
    logic [CNT_W-1:0]        cnt;
    logic signed [VAL_W-1:0] val;
  } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ats_cell.sv =====
// ----------------------------------------------------------------------------
// ats_cell: one slot of the element row
// Holds one element, hands it to both neighbours and takes a neighbour's
// element, the new value or its own according to the broadcast operation.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_cell
  import ats_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  wire logic                    clk_i,
  input  wire ctl_t                    ctl_i,
  input  wire logic signed [VAL_W-1:0] low_value_i,
  input  wire logic                    low_move_i,
  input  wire logic signed [VAL_W-1:0] high_value_i,
  input  wire logic                    high_sg_i,
  output logic signed [VAL_W-1:0]      value_o,
  output logic                         sg_o,
  output logic signed [VAL_W-1:0]      rd_o,
  output logic                         viol_o
);

  localparam logic [CNT_W-1:0] MyIdx  = CNT_W'(Idx);
  localparam logic [CNT_W:0]   MyNext = (CNT_W + 1)'(Idx + 1);

  logic signed [VAL_W-1:0] value_q, value_d;
  logic                    in_range;
  logic                    gt;

  assign value_o = value_q;

  always_comb begin
    in_range = MyIdx < ctl_i.cnt;
    gt       = in_range && (value_q > ctl_i.val);
    // sg: this slot is unheld, or it and every held slot above it are greater than the value
    sg_o     = !in_range || (gt && high_sg_i);
    rd_o     = (MyIdx == ctl_i.pos) ? value_q : '0;
    viol_o   = (MyNext < {1'b0, ctl_i.cnt}) && (value_q > high_value_i);
  end

  always_comb begin
    value_d = value_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (MyIdx == ctl_i.pos) begin
          value_d = ctl_i.val;
        end else if (MyIdx > ctl_i.pos && MyIdx <= ctl_i.cnt) begin
          value_d = low_value_i;
        end
      end
      OP_DELETE: begin
        if (MyIdx >= ctl_i.pos) begin
          value_d = high_value_i;
        end
      end
      OP_SET: begin
        if (MyIdx == ctl_i.pos) begin
          value_d = ctl_i.val;
        end
      end
      OP_SORTED: begin
        if (low_move_i) begin
          value_d = low_value_i;
        end else if (sg_o) begin
          value_d = ctl_i.val;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== rtl/array_table_with_sorted_insert.sv =====
// Result: registered, valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the result is taken; every command
// is done by the cell row in a single parallel update.
// Reset: fill count cleared, capacity limit set to 32, output empty; element
// slots are not cleared.
// ----------------------------------------------------------------------------
// array_table_with_sorted_insert: packed element table in a row of cells
// Append, insert, delete, get, set, sorted insert and order check on a table
// of signed 32-bit elements, with a run-time capacity limit.
// ----------------------------------------------------------------------------
`default_nettype none

module array_table_with_sorted_insert
  import ats_pkg::*;
#(
  parameter int unsigned CAPACITY = ATS_CAPACITY
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CNT_W-1:0]        cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [CMD_W-1:0]        command_i,
  input  wire logic [CNT_W-1:0]        position_i,
  input  wire logic signed [VAL_W-1:0] element_value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [VAL_W-1:0]      read_value_o,
  output logic                         ok_o,
  output logic                         sorted_flag_o,
  output logic [CNT_W-1:0]             fill_count_o
);

  // the count never passes the 6-bit limit, so slots above 63 are unreachable
  localparam int unsigned NCell = (CAPACITY < 63) ? CAPACITY : 63;
  localparam logic [CNT_W-1:0] NCellC = CNT_W'(NCell);

  logic [CNT_W-1:0]        limit_q;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] rd_q, rd_d;
  logic                    ok_q, ok_d;
  logic                    srt_q, srt_d;

  logic                    accept;
  logic                    full;
  logic                    pos_in;
  cmd_e                    cmd;
  ctl_t                    ctl;
  logic signed [VAL_W-1:0] read_any;
  logic                    viol_any;

  logic signed [VAL_W-1:0] cell_val  [NCell];
  logic                    cell_sg   [NCell];
  logic signed [VAL_W-1:0] cell_rd   [NCell];
  logic                    cell_viol [NCell];

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = !out_valid_q || out_ready_i;
  assign accept        = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign read_value_o  = rd_q;
  assign ok_o          = ok_q;
  assign sorted_flag_o = srt_q;
  assign fill_count_o  = cnt_q;

  always_comb begin
    read_any = '0;
    viol_any = 1'b0;
    for (int i = 0; i < NCell; i++) begin
      read_any = read_any | cell_rd[i];
      viol_any = viol_any | cell_viol[i];
    end
  end

  always_comb begin
    cmd     = cmd_e'(command_i);
    full    = (cnt_q >= limit_q) || (cnt_q >= NCellC);
    pos_in  = position_i < cnt_q;
    ok_d    = 1'b0;
    rd_d    = '0;
    srt_d   = 1'b0;
    cnt_d   = cnt_q;
    ctl.op  = OP_HOLD;
    ctl.pos = position_i;
    ctl.cnt = cnt_q;
    ctl.val = element_value_i;
    case (cmd)
      CMD_APPEND: begin
        ok_d    = !full;
        ctl.op  = OP_INSERT;
        ctl.pos = cnt_q;
      end
      CMD_INSERT: begin
        ok_d   = !full && (position_i <= cnt_q);
        ctl.op = OP_INSERT;
      end
      CMD_DELETE: begin
        ok_d   = pos_in;
        ctl.op = OP_DELETE;
        rd_d   = pos_in ? read_any : '0;
      end
      CMD_GET: begin
        ok_d = pos_in;
        rd_d = pos_in ? read_any : '0;
      end
      CMD_SET: begin
        ok_d   = pos_in;
        ctl.op = OP_SET;
      end
      CMD_SORTED: begin
        ok_d   = !full;
        ctl.op = OP_SORTED;
      end
      CMD_CHECK: begin
        ok_d  = 1'b1;
        srt_d = !viol_any;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (!accept || !ok_d) begin
      ctl.op = OP_HOLD;
    end
    if (ok_d) begin
      if (cmd == CMD_APPEND || cmd == CMD_INSERT || cmd == CMD_SORTED) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else if (cmd == CMD_DELETE) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  for (genvar g = 0; g < NCell; g++) begin : g_cell
    logic signed [VAL_W-1:0] low_val, high_val;
    logic                    low_move, high_sg;
    if (g == 0) begin : g_bot
      assign low_val  = '0;
      assign low_move = 1'b0;
    end else begin : g_mid_lo
      assign low_val  = cell_val[g-1];
      assign low_move = cell_sg[g-1];
    end
    if (g == NCell - 1) begin : g_top
      assign high_val = '0;
      assign high_sg  = 1'b1;
    end else begin : g_mid_hi
      assign high_val = cell_val[g+1];
      assign high_sg  = cell_sg[g+1];
    end
    ats_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .low_value_i (low_val),
      .low_move_i  (low_move),
      .high_value_i(high_val),
      .high_sg_i   (high_sg),
      .value_o     (cell_val[g]),
      .sg_o        (cell_sg[g]),
      .rd_o        (cell_rd[g]),
      .viol_o      (cell_viol[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= CNT_W'(32);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q  <= rd_d;
      ok_q  <= ok_d;
      srt_q <= srt_d;
    end
  end

  // count stays within the cell row
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= NCellC)
    else $error("fill count beyond cell row");

  // count changes only on an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> cnt_q == $past(cnt_q))
    else $error("fill count changed without a request");

  // order check is never rejected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i == CMD_CHECK |=> ok_o && out_valid_o)
    else $error("order check rejected");

  // a get leaves the count as it was
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i == CMD_GET |=> fill_count_o == $past(cnt_q))
    else $error("get changed the fill count");

endmodule

`default_nettype wire
